/* rtl/nfra_pkg.sv */
// Shared types, codes and defaults of the next-fit region allocator.
package nfra_pkg;

  localparam int unsigned PAGE_BYTES_DEF  = 4096;
  localparam int unsigned SMALL_ALIGN_DEF = 16;
  localparam int unsigned MAX_REGIONS_DEF = 64;
  localparam int unsigned MAX_SLOTS_DEF   = 64;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CLEAR   = 2'd2
  } nfra_op_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NOSPACE  = 3'd1,
    STS_NOTFOUND = 3'd2,
    STS_FULL     = 3'd3,
    STS_TOOBIG   = 3'd4
  } nfra_status_e;

  typedef enum logic {
    CFG_MODE = 1'b0,
    CFG_BUF  = 1'b1
  } nfra_cfg_idx_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_ROUND, ST_DISP, ST_BUMP1, ST_BUMP2, ST_CLEAR,
    ST_SC_RD, ST_SC_CHK, ST_ER_RD, ST_ER_WR,
    ST_PUT_EV, ST_PUT_SH, ST_PUT_SW,
    ST_A_SINIT, ST_A_SRD, ST_A_SCHK1, ST_A_SCHK2, ST_A_SLOT,
    ST_A_FIT1, ST_A_FIT2, ST_A_COMMIT, ST_A_PUTL, ST_A_PUTR, ST_A_OK,
    ST_R_RD, ST_R_CHK, ST_R_GOTR, ST_R_EVAL1, ST_R_EVAL2,
    ST_R_ERSL, ST_R_PUT, ST_R_FIN,
    ST_DONE
  } nfra_state_e;

  typedef struct packed {
    logic        overwrite_mode;
    logic [31:0] buffer_bytes;
  } nfra_cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] data_bytes;
    logic [31:0] initial_meta_bytes;
    logic [31:0] extra_meta_bytes;
    logic [31:0] release_offset;
  } nfra_req_t;

  typedef struct packed {
    nfra_status_e status;
    logic [31:0]  slot_offset;
    logic [31:0]  slot_bytes;
    logic         overflow_seen;
  } nfra_res_t;

endpackage

/* rtl/nfra_ram.sv */
// Single-port-write, single-port-read memory with registered read data.
module nfra_ram #(
  parameter int unsigned W     = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* rtl/nfra_ctrl.sv */
// Sequencer and shared datapath that walks the free-region and slot tables.
module nfra_ctrl import nfra_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned SMALL_ALIGN = SMALL_ALIGN_DEF,
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int unsigned MAX_SLOTS   = MAX_SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  nfra_cfg_t cfg_i,
  input  logic      start_i,
  input  nfra_req_t req_i,
  output logic      idle_o,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output nfra_res_t res_o
);

  localparam int unsigned RW  = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW  = $clog2(MAX_REGIONS);
  localparam int unsigned SW  = $clog2(MAX_SLOTS + 1);
  localparam int unsigned SAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [34:0] PG  = 35'(PAGE_BYTES);
  localparam logic [34:0] PGM = 35'(PAGE_BYTES - 1);
  localparam logic [34:0] SAM = 35'(SMALL_ALIGN - 1);

  function automatic logic [34:0] rnd(input logic [34:0] v);
    logic [34:0] m;
    m = (v >= PG) ? PGM : SAM;
    return (v + m) & ~m;
  endfunction

  nfra_state_e state_q, state_d, ret_q, ret_d, pret_q, pret_d;
  logic [1:0]  op_q, op_d;
  logic [31:0] rel_q, rel_d;
  logic [33:0] raw_q, raw_d;
  logic [34:0] size_q, size_d;
  logic [RW-1:0] n_q, n_d;
  logic [31:0] cursor_q, cursor_d, bump_q, bump_d;
  logic        ovf_q, ovf_d;
  logic [MAX_SLOTS-1:0] valid_q, valid_d;
  logic [33:0] key_q, key_d;
  logic [RW-1:0] idx_q, idx_d, k_q, k_d, p_q, p_d, i_q, i_d, c_q, c_d, j_q, j_d;
  logic [RW-1:0] right_q, right_d, left_q, left_d;
  logic [31:0] prev_s_q, prev_s_d, prev_l_q, prev_l_d, hit_s_q, hit_s_d, hit_l_q, hit_l_d;
  logic [31:0] put_s_q, put_s_d, put_l_q, put_l_d;
  logic [32:0] a_q, a_d, end_q, end_d, cand_q, cand_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [33:0] ce_q, ce_d, ne_q, ne_d;
  logic [31:0] lgap_q, lgap_d, rgap_q, rgap_d, ns_q, ns_d, rlen_q, rlen_d;
  logic        fits_q, fits_d, rm_q, rm_d, pm_q, pm_d, leq_q, leq_d;
  nfra_status_e sts_q, sts_d;
  logic [31:0] off_q, off_d, len_q, len_d;

  logic          rg_we;
  logic [AW-1:0] rg_waddr, rg_raddr;
  logic [63:0]   rg_wdata, rg_rdata;
  logic [31:0]   rd_s, rd_l;
  logic          lv_we;
  logic [SAW-1:0] lv_addr;
  logic [63:0]   lv_rdata;

  logic [RW:0]   k1;
  logic [RW-1:0] ii;
  logic [34:0]   rsum;
  logic [RW:0]   need;
  logic          fits_c, grow;

  assign rd_s = rg_rdata[63:32];
  assign rd_l = rg_rdata[31:0];
  assign lv_addr = slot_q[SAW-1:0];

  nfra_ram #(.W(64), .DEPTH(MAX_REGIONS), .AW(AW)) u_regions (
    .clk_i   (clk_i),
    .we_i    (rg_we),
    .waddr_i (rg_waddr),
    .wdata_i (rg_wdata),
    .raddr_i (rg_raddr),
    .rdata_o (rg_rdata)
  );

  nfra_ram #(.W(64), .DEPTH(MAX_SLOTS), .AW(SAW)) u_slots (
    .clk_i   (clk_i),
    .we_i    (lv_we),
    .waddr_i (lv_addr),
    .wdata_i ({cand_q[31:0], size_q[31:0]}),
    .raddr_i (lv_addr),
    .rdata_o (lv_rdata)
  );

  always_comb begin
    state_d = state_q; ret_d = ret_q; pret_d = pret_q;
    op_d = op_q; rel_d = rel_q; raw_d = raw_q; size_d = size_q; n_d = n_q;
    cursor_d = cursor_q; bump_d = bump_q; ovf_d = ovf_q; valid_d = valid_q;
    key_d = key_q; idx_d = idx_q; k_d = k_q; p_d = p_q; i_d = i_q; c_d = c_q; j_d = j_q;
    right_d = right_q; left_d = left_q;
    prev_s_d = prev_s_q; prev_l_d = prev_l_q; hit_s_d = hit_s_q; hit_l_d = hit_l_q;
    put_s_d = put_s_q; put_l_d = put_l_q;
    a_d = a_q; end_d = end_q; cand_d = cand_q; slot_d = slot_q; ce_d = ce_q; ne_d = ne_q;
    lgap_d = lgap_q; rgap_d = rgap_q; ns_d = ns_q; rlen_d = rlen_q;
    fits_d = fits_q; rm_d = rm_q; pm_d = pm_q; leq_d = leq_q;
    sts_d = sts_q; off_d = off_q; len_d = len_q;
    rg_we = 1'b0; rg_waddr = '0; rg_wdata = '0; rg_raddr = '0; lv_we = 1'b0;
    idle_o = 1'b0; res_valid_o = 1'b0;
    k1 = {1'b0, k_q} + (RW+1)'(1);
    ii = (i_q >= n_q) ? '0 : i_q;
    rsum = {2'b0, a_q} + {2'b0, size_q[32:0]};
    fits_c = ({1'b0, cand_q} >= {2'b0, prev_s_q}) && ({1'b0, ce_q} <= {2'b0, end_q});
    // gaps on either side of the slot each add one region
    need = {1'b0, n_q} - (RW+1)'(1) + (RW+1)'(cand_q[31:0] != prev_s_q)
         + (RW+1)'(end_q[31:0] != ce_q[31:0]);
    grow = (ne_q > {2'b0, ns_q}) && !pm_q && !rm_q && !leq_q;

    case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
        if (start_i) begin
          op_d  = req_i.opcode;
          rel_d = req_i.release_offset;
          raw_d = {2'b0, req_i.data_bytes} + {2'b0, req_i.initial_meta_bytes}
                + {2'b0, req_i.extra_meta_bytes};
          sts_d = STS_OK; off_d = '0; len_d = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        size_d  = rnd({1'b0, raw_q});
        state_d = ST_DISP;
      end
      ST_DISP: begin
        case (nfra_op_e'(op_q))
          OP_ALLOC: begin
            if (size_q > {3'b0, cfg_i.buffer_bytes}) begin
              sts_d = STS_TOOBIG; state_d = ST_DONE;
            end else if (cfg_i.overwrite_mode) begin
              state_d = ST_BUMP1;
            end else begin
              key_d = {2'b0, cursor_q}; idx_d = '0; ret_d = ST_A_SINIT;
              state_d = ST_SC_RD;
            end
          end
          OP_RELEASE: begin
            if (cfg_i.overwrite_mode) begin
              state_d = ST_DONE;
            end else begin
              slot_d = '0; state_d = ST_R_RD;
            end
          end
          OP_CLEAR: state_d = ST_CLEAR;
          default:  state_d = ST_DONE;
        endcase
      end
      ST_BUMP1: begin
        a_d     = 33'(rnd({3'b0, bump_q}));
        state_d = ST_BUMP2;
      end
      ST_BUMP2: begin
        cand_d  = (rsum > {3'b0, cfg_i.buffer_bytes}) ? '0 : a_q;
        // bump path reuses the commit result fields but not the tables
        bump_d  = ((rsum > {3'b0, cfg_i.buffer_bytes}) ? size_q[31:0] : rsum[31:0]);
        off_d   = (rsum > {3'b0, cfg_i.buffer_bytes}) ? '0 : a_q[31:0];
        len_d   = size_q[31:0];
        state_d = ST_DONE;
      end
      ST_CLEAR: begin
        valid_d = '0; bump_d = '0; cursor_d = '0;
        n_d = (cfg_i.buffer_bytes != '0) ? RW'(1) : '0;
        rg_we = 1'b1; rg_waddr = '0; rg_wdata = {32'd0, cfg_i.buffer_bytes};
        state_d = ST_DONE;
      end

      // lower-bound scan: first index whose start is not below key
      ST_SC_RD: begin
        if (idx_q == n_q) begin
          state_d = ret_q;
        end else begin
          rg_raddr = idx_q[AW-1:0];
          state_d  = ST_SC_CHK;
        end
      end
      ST_SC_CHK: begin
        if ({2'b0, rd_s} < key_q) begin
          prev_s_d = rd_s; prev_l_d = rd_l;
          idx_d = idx_q + RW'(1);
          state_d = ST_SC_RD;
        end else begin
          hit_s_d = rd_s; hit_l_d = rd_l;
          state_d = ret_q;
        end
      end

      // erase entry k: shift the tail down one place
      ST_ER_RD: begin
        if (k_q >= n_q) begin
          state_d = pret_q;
        end else if (k1 >= {1'b0, n_q}) begin
          n_d = n_q - RW'(1);
          state_d = pret_q;
        end else begin
          rg_raddr = k1[AW-1:0];
          state_d  = ST_ER_WR;
        end
      end
      ST_ER_WR: begin
        rg_we = 1'b1; rg_waddr = k_q[AW-1:0]; rg_wdata = rg_rdata;
        k_d = k_q + RW'(1);
        state_d = ST_ER_RD;
      end

      // insert or overwrite after the lower-bound scan
      ST_PUT_EV: begin
        p_d = idx_q;
        if (idx_q < n_q && hit_s_q == put_s_q) begin
          rg_we = 1'b1; rg_waddr = idx_q[AW-1:0]; rg_wdata = {put_s_q, put_l_q};
          state_d = pret_q;
        end else if (n_q >= RW'(MAX_REGIONS)) begin
          state_d = pret_q;
        end else begin
          k_d = n_q; state_d = ST_PUT_SH;
        end
      end
      ST_PUT_SH: begin
        if (k_q == p_q) begin
          rg_we = 1'b1; rg_waddr = p_q[AW-1:0]; rg_wdata = {put_s_q, put_l_q};
          n_d = n_q + RW'(1);
          state_d = pret_q;
        end else begin
          rg_raddr = AW'(k_q - RW'(1));
          state_d  = ST_PUT_SW;
        end
      end
      ST_PUT_SW: begin
        rg_we = 1'b1; rg_waddr = k_q[AW-1:0]; rg_wdata = rg_rdata;
        k_d = k_q - RW'(1);
        state_d = ST_PUT_SH;
      end

      // keep-mode allocation
      ST_A_SINIT: begin
        i_d = idx_q; c_d = '0; state_d = ST_A_SRD;
      end
      ST_A_SRD: begin
        if (c_q == n_q) begin
          ovf_d = 1'b1; sts_d = STS_NOSPACE; state_d = ST_DONE;
        end else begin
          i_d = ii; rg_raddr = ii[AW-1:0]; state_d = ST_A_SCHK1;
        end
      end
      ST_A_SCHK1: begin
        a_d   = 33'(rnd({3'b0, rd_s}));
        end_d = {1'b0, rd_s} + {1'b0, rd_l};
        state_d = ST_A_SCHK2;
      end
      ST_A_SCHK2: begin
        if ({2'b0, end_q} >= rsum) begin
          cand_d = a_q; slot_d = '0; state_d = ST_A_SLOT;
        end else begin
          i_d = i_q + RW'(1); c_d = c_q + RW'(1); state_d = ST_A_SRD;
        end
      end
      ST_A_SLOT: begin
        if (slot_q == SW'(MAX_SLOTS)) begin
          sts_d = STS_FULL; state_d = ST_DONE;
        end else if (!valid_q[lv_addr]) begin
          key_d = {1'b0, cand_q} + 34'd1; idx_d = '0; ret_d = ST_A_FIT1;
          state_d = ST_SC_RD;
        end else begin
          slot_d = slot_q + SW'(1);
        end
      end
      ST_A_FIT1: begin
        j_d   = idx_q - RW'(1);
        end_d = {1'b0, prev_s_q} + {1'b0, prev_l_q};
        ce_d  = {1'b0, cand_q} + {1'b0, size_q[32:0]};
        state_d = ST_A_FIT2;
      end
      ST_A_FIT2: begin
        fits_d = fits_c;
        lgap_d = cand_q[31:0] - prev_s_q;
        rgap_d = end_q[31:0] - ce_q[31:0];
        if (fits_c && need > (RW+1)'(MAX_REGIONS)) begin
          sts_d = STS_FULL; state_d = ST_DONE;
        end else begin
          state_d = ST_A_COMMIT;
        end
      end
      ST_A_COMMIT: begin
        cursor_d = ce_q[31:0];
        lv_we = 1'b1;
        valid_d[lv_addr] = 1'b1;
        if (fits_q) begin
          k_d = j_q; pret_d = ST_A_PUTL; state_d = ST_ER_RD;
        end else begin
          state_d = ST_A_OK;
        end
      end
      ST_A_PUTL: begin
        if (lgap_q != '0) begin
          put_s_d = prev_s_q; put_l_d = lgap_q; key_d = {2'b0, prev_s_q};
          idx_d = '0; ret_d = ST_PUT_EV; pret_d = ST_A_PUTR; state_d = ST_SC_RD;
        end else begin
          state_d = ST_A_PUTR;
        end
      end
      ST_A_PUTR: begin
        if (rgap_q != '0) begin
          put_s_d = ce_q[31:0]; put_l_d = rgap_q; key_d = {2'b0, ce_q[31:0]};
          idx_d = '0; ret_d = ST_PUT_EV; pret_d = ST_A_OK; state_d = ST_SC_RD;
        end else begin
          state_d = ST_A_OK;
        end
      end
      ST_A_OK: begin
        off_d = cand_q[31:0]; len_d = size_q[31:0]; state_d = ST_DONE;
      end

      // keep-mode release
      ST_R_RD: begin
        if (slot_q == SW'(MAX_SLOTS)) begin
          sts_d = STS_NOTFOUND; state_d = ST_DONE;
        end else if (!valid_q[lv_addr]) begin
          slot_d = slot_q + SW'(1);
        end else begin
          state_d = ST_R_CHK;
        end
      end
      ST_R_CHK: begin
        if (lv_rdata[63:32] == rel_q) begin
          ns_d  = lv_rdata[63:32];
          ne_d  = {2'b0, lv_rdata[63:32]} + {2'b0, lv_rdata[31:0]};
          key_d = {2'b0, lv_rdata[63:32]} + {2'b0, lv_rdata[31:0]};
          idx_d = '0; ret_d = ST_R_GOTR; state_d = ST_SC_RD;
        end else begin
          slot_d = slot_q + SW'(1); state_d = ST_R_RD;
        end
      end
      ST_R_GOTR: begin
        right_d = idx_q;
        rm_d    = (idx_q < n_q) && ({2'b0, hit_s_q} == ne_q);
        rlen_d  = hit_l_q;
        key_d   = {2'b0, ns_q}; idx_d = '0; ret_d = ST_R_EVAL1;
        state_d = ST_SC_RD;
      end
      ST_R_EVAL1: begin
        left_d = idx_q;
        pm_d   = (idx_q != '0) && (({1'b0, prev_s_q} + {1'b0, prev_l_q}) == {1'b0, ns_q});
        leq_d  = (idx_q < n_q) && (hit_s_q == ns_q);
        state_d = ST_R_EVAL2;
      end
      ST_R_EVAL2: begin
        if (grow && n_q >= RW'(MAX_REGIONS)) begin
          sts_d = STS_FULL; state_d = ST_DONE;
        end else if (rm_q) begin
          ne_d = ne_q + {2'b0, rlen_q};
          k_d = right_q; pret_d = ST_R_ERSL; state_d = ST_ER_RD;
        end else begin
          state_d = ST_R_ERSL;
        end
      end
      ST_R_ERSL: begin
        if (pm_q) begin
          ns_d = prev_s_q;
          k_d = left_q - RW'(1); pret_d = ST_R_PUT; state_d = ST_ER_RD;
        end else begin
          state_d = ST_R_PUT;
        end
      end
      ST_R_PUT: begin
        if (ne_q > {2'b0, ns_q}) begin
          put_s_d = ns_q; put_l_d = ne_q[31:0] - ns_q; key_d = {2'b0, ns_q};
          idx_d = '0; ret_d = ST_PUT_EV; pret_d = ST_R_FIN; state_d = ST_SC_RD;
        end else begin
          state_d = ST_R_FIN;
        end
      end
      ST_R_FIN: begin
        valid_d[lv_addr] = 1'b0; state_d = ST_DONE;
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_o = '{status: sts_q, slot_offset: off_q, slot_bytes: len_q,
                   overflow_seen: ovf_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      n_q      <= '0;
      cursor_q <= '0;
      bump_q   <= '0;
      ovf_q    <= 1'b0;
      valid_q  <= '0;
    end else begin
      state_q  <= state_d;
      n_q      <= n_d;
      cursor_q <= cursor_d;
      bump_q   <= bump_d;
      ovf_q    <= ovf_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ret_q <= ret_d; pret_q <= pret_d;
    op_q <= op_d; rel_q <= rel_d; raw_q <= raw_d; size_q <= size_d;
    key_q <= key_d; idx_q <= idx_d; k_q <= k_d; p_q <= p_d; i_q <= i_d; c_q <= c_d;
    j_q <= j_d; right_q <= right_d; left_q <= left_d;
    prev_s_q <= prev_s_d; prev_l_q <= prev_l_d; hit_s_q <= hit_s_d; hit_l_q <= hit_l_d;
    put_s_q <= put_s_d; put_l_q <= put_l_d;
    a_q <= a_d; end_q <= end_d; cand_q <= cand_d; slot_q <= slot_d; ce_q <= ce_d;
    ne_q <= ne_d; lgap_q <= lgap_d; rgap_q <= rgap_d; ns_q <= ns_d; rlen_q <= rlen_d;
    fits_q <= fits_d; rm_q <= rm_d; pm_q <= pm_d; leq_q <= leq_d;
    sts_q <= sts_d; off_q <= off_d; len_q <= len_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= RW'(MAX_REGIONS))
    else $error("region count above table depth");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q)
    else $error("overflow flag dropped");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status != STS_OK) |->
      (res_o.slot_offset == '0 && res_o.slot_bytes == '0))
    else $error("failed request carries a slot");

endmodule

/* rtl/next_fit_region_allocator_core.sv */
// Top level of the next-fit region allocator: ports, config and result register.
//
//  channel | direction | handshake                  | payload
//  s_axis  | in        | s_axis_tvalid/s_axis_tready | tuser opcode, tdata request
//  m_axis  | out       | m_axis_tvalid/m_axis_tready | tuser status+flag, tdata slot
//  cfg     | in        | cfg_valid_i/cfg_ready_o     | cfg_index_i, cfg_data_i
//
// One item at a time through a sequencer over one region-table memory port.
// Too-large requests, overwrite releases, unused opcodes, clear and overwrite
// allocation do not scan the tables; keep-mode work adds lower-bound table scans,
// the next-fit walk over the free regions, a scan over up to MAX_SLOTS slots and
// shifts of the region table.
// Reset empties the region table and slot table at once; no sweep is needed.
// A finished result waits in the output register while the next item is taken.
module next_fit_region_allocator_core import nfra_pkg::*; #(
  parameter int unsigned PAGE_BYTES  = PAGE_BYTES_DEF,
  parameter int unsigned SMALL_ALIGN = SMALL_ALIGN_DEF,
  parameter int unsigned MAX_REGIONS = MAX_REGIONS_DEF,
  parameter int unsigned MAX_SLOTS   = MAX_SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] data_bytes, [63:32] initial_meta_bytes, [95:64] extra_meta_bytes,
  // [127:96] release_offset
  input  logic [127:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] slot_offset, [63:32] slot_bytes
  output logic [63:0]  m_axis_tdata,
  // [2:0] status, [3] overflow_seen
  output logic [3:0]   m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic         cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  nfra_cfg_t cfg_q, cfg_d;
  nfra_req_t req;
  nfra_res_t res, out_q;
  logic      idle, res_valid, res_ready, out_valid_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (nfra_cfg_idx_e'(cfg_index_i))
        CFG_MODE: cfg_d.overwrite_mode = cfg_data_i[0];
        CFG_BUF:  cfg_d.buffer_bytes   = cfg_data_i;
        default:  cfg_d = cfg_q;
      endcase
    end
  end

  assign req = '{opcode: s_axis_tuser, data_bytes: s_axis_tdata[31:0],
                 initial_meta_bytes: s_axis_tdata[63:32],
                 extra_meta_bytes: s_axis_tdata[95:64],
                 release_offset: s_axis_tdata[127:96]};

  assign s_axis_tready = idle;
  assign res_ready     = !out_valid_q || m_axis_tready;

  nfra_ctrl #(
    .PAGE_BYTES  (PAGE_BYTES),
    .SMALL_ALIGN (SMALL_ALIGN),
    .MAX_REGIONS (MAX_REGIONS),
    .MAX_SLOTS   (MAX_SLOTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .start_i     (s_axis_tvalid && idle),
    .req_i       (req),
    .idle_o      (idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result until taken
  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.slot_bytes, out_q.slot_offset};
  assign m_axis_tuser  = {out_q.overflow_seen, out_q.status};

endmodule
